/* hdl/sob_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sob_pkg
// Shared widths, types and the cosine lookup table for the oscillator bank.
// ----------------------------------------------------------------------------
package sob_pkg;

  localparam int BANK_SIZE      = 16;
  localparam int BANK_IDX_W     = $clog2(BANK_SIZE);
  localparam int RESULT_LIMIT   = 16;
  localparam int TICK_LIMIT     = (BANK_SIZE < RESULT_LIMIT) ? BANK_SIZE : RESULT_LIMIT;
  localparam int INDEX_W        = 4;
  localparam int PHASE_W        = 32;
  localparam int WEIGHT_W       = 16;
  localparam int SAMPLE_W       = 16;
  localparam int VALUE_W        = 32;
  localparam int COUNT_W        = 5;
  localparam int TABLE_BITS     = 10;
  localparam int TABLE_LEN      = 1 << TABLE_BITS;
  localparam int QBITS          = TABLE_BITS - 2;
  localparam int IN_TDATA_W     = 104;
  localparam int OUT_TDATA_W    = 40;
  localparam int OUT_PAD_W      = OUT_TDATA_W - VALUE_W - INDEX_W;
  localparam int OUT_FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
  localparam int OUTSTANDING_W  = $clog2(OUT_FIFO_DEPTH + 1);

  localparam logic [COUNT_W-1:0] IN_USE_RESET = COUNT_W'(16);

  // pi/2 in Q62
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  // One oscillator's stored state
  typedef struct packed {
    logic        [PHASE_W-1:0]  phase;
    logic        [PHASE_W-1:0]  incr;
    logic signed [WEIGHT_W-1:0] wcos;
    logic signed [WEIGHT_W-1:0] wsin;
  } osc_entry_t;

  // Travels with each oscillator down the tick pipeline
  typedef struct packed {
    logic               last;
    logic [INDEX_W-1:0] index;
  } tick_tag_t;

  typedef struct packed {
    logic                      last;
    logic        [INDEX_W-1:0] index;
    logic signed [VALUE_W-1:0] value;
  } result_t;

  typedef logic signed [SAMPLE_W-1:0] cos_rom_t [TABLE_LEN];

  // (a*b) >> 62, keeping 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Divide a series term by j*(j+1)
  function automatic logic [63:0] div_term(input logic [63:0] t, input logic [5:0] j);
    logic [63:0] q;
    case (j)
      6'd1:    q = t / 2;
      6'd2:    q = t / 6;
      6'd3:    q = t / 12;
      6'd4:    q = t / 20;
      6'd5:    q = t / 30;
      6'd6:    q = t / 42;
      6'd7:    q = t / 56;
      6'd8:    q = t / 72;
      6'd9:    q = t / 90;
      6'd10:   q = t / 110;
      6'd11:   q = t / 132;
      6'd12:   q = t / 156;
      6'd13:   q = t / 182;
      6'd14:   q = t / 210;
      6'd15:   q = t / 240;
      6'd16:   q = t / 272;
      6'd17:   q = t / 306;
      6'd18:   q = t / 342;
      6'd19:   q = t / 380;
      6'd20:   q = t / 420;
      6'd21:   q = t / 462;
      6'd22:   q = t / 506;
      6'd23:   q = t / 552;
      6'd24:   q = t / 600;
      6'd25:   q = t / 650;
      6'd26:   q = t / 702;
      6'd27:   q = t / 756;
      6'd28:   q = t / 812;
      6'd29:   q = t / 870;
      6'd30:   q = t / 930;
      6'd31:   q = t / 992;
      6'd32:   q = t / 1056;
      default: q = t;
    endcase
    return q;
  endfunction

  // Taylor series in Q62: cosine, or sine when odd_start is set
  function automatic logic [63:0] series_q62(input logic [63:0] x, input logic odd_start);
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    logic        [5:0]  j;
    x2   = mul_q62(x, x);
    term = odd_start ? x : 64'h4000_0000_0000_0000;
    sum  = signed'(term);
    for (int n = 1; n <= 16; n++) begin
      j    = odd_start ? 6'(2 * n) : 6'(2 * n - 1);
      term = div_term(mul_q62(term, x2), j);
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    return unsigned'(sum);
  endfunction

  // round(32767*cos(2*pi*k/TABLE_LEN)), half away from zero
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t    rom;
    logic [63:0] hi_part;
    logic [63:0] lo_part;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] c;
    logic [63:0] v;
    logic [1:0]  quad;
    hi_part = HALF_PI_Q62 >> QBITS;
    lo_part = HALF_PI_Q62 & ((64'd1 << QBITS) - 64'd1);
    for (int k = 0; k < TABLE_LEN; k++) begin
      quad = 2'(k >> QBITS);
      r    = 64'(k) & ((64'd1 << QBITS) - 64'd1);
      x    = hi_part * r + ((lo_part * r) >> QBITS);
      c    = series_q62(x, quad[0]);
      v    = ((c >> 30) * 64'd32767 + 64'h8000_0000) >> 32;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      if (quad == 2'd1 || quad == 2'd2) begin
        rom[k] = -signed'(v[SAMPLE_W-1:0]);
      end else begin
        rom[k] = signed'(v[SAMPLE_W-1:0]);
      end
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

/* hdl/sine_oscillator_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_oscillator_bank
// Bank of sixteen table-driven sine oscillators with exact phase accumulators.
// ----------------------------------------------------------------------------
// A load transfer (tuser 0) sets one oscillator's increment, weights and a
// phase of increment times start offset; the input waits for the write. A
// tick transfer (tuser 1) streams one result per oscillator in use, index
// order, tlast on the final one, and advances those phases. The tick walks
// the state memory one entry per cycle, unless paused, through its single
// read port, holding the input busy. Results are registered at the read,
// table and products, then enter an eight-deep queue that decouples the
// output; the walk pauses while queued and in-flight results fill it. The
// state clears at reset with no clearing pass. cfg_data sets the number in
// use (values above sixteen act as sixteen, zero gives ticks no results).
// ----------------------------------------------------------------------------
module sine_oscillator_bank (
  input  logic                                clk,
  input  logic                                rst,
  // tdata: oscillator_index[3:0], phase_increment[35:4], cosine_weight[51:36],
  //        sine_weight[67:52], start_offset[99:68], zero pad[103:100]
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sob_pkg::IN_TDATA_W-1:0]      s_tdata,
  // tuser: opcode[0]
  input  logic                                s_tuser,
  // tdata: source_index[3:0], weighted_value[35:4], zero pad[39:36]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sob_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sob_pkg::COUNT_W-1:0]         cfg_data
);
  import sob_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TICK,
    ST_DRAIN
  } state_t;

  state_t                    state;
  logic [COUNT_W-1:0]        in_use;
  logic [COUNT_W-1:0]        tick_count;

  // Load holding registers
  logic [INDEX_W-1:0]        ld_idx;
  logic [PHASE_W-1:0]        ld_inc;
  logic [PHASE_W-1:0]        ld_off;
  logic signed [WEIGHT_W-1:0] ld_wcos;
  logic signed [WEIGHT_W-1:0] ld_wsin;
  logic [PHASE_W-1:0]        ld_phase;

  // Tick sequencer
  logic [INDEX_W-1:0]        osc_cnt;
  logic [INDEX_W-1:0]        last_cnt;
  logic [OUTSTANDING_W-1:0]  outstanding;
  logic                      issue;
  logic                      in_xfer;
  logic                      out_xfer;

  // Pipeline stages
  logic                      s1_valid;
  tick_tag_t                 s1_tag;
  osc_entry_t                s1_entry;
  logic                      s2_valid;
  tick_tag_t                 s2_tag;
  logic signed [WEIGHT_W-1:0] s2_wcos;
  logic signed [WEIGHT_W-1:0] s2_wsin;
  logic [TABLE_BITS-1:0]     cos_addr;
  logic [TABLE_BITS-1:0]     sin_addr;
  logic signed [SAMPLE_W-1:0] cos_val;
  logic signed [SAMPLE_W-1:0] sin_val;
  logic                      res_valid;
  result_t                   res;
  result_t                   out_res;

  // Store write port
  logic                      wr_en;
  logic                      wr_load;
  logic [BANK_IDX_W-1:0]     wr_addr;
  osc_entry_t                wr_entry;

  assign in_xfer   = s_tvalid && s_tready;
  assign out_xfer  = m_tvalid && m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign issue     = (state == ST_TICK) && (outstanding < OUTSTANDING_W'(OUT_FIFO_DEPTH));

  // Clamp the number in use to the bank
  assign tick_count = (in_use > COUNT_W'(TICK_LIMIT)) ? COUNT_W'(TICK_LIMIT) : in_use;

  // Sequencer state, configuration and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      in_use      <= IN_USE_RESET;
      outstanding <= '0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        in_use <= cfg_data;
      end
      s1_valid <= issue;
      s2_valid <= s1_valid;
      case ({issue, out_xfer})
        2'b10:   outstanding <= outstanding + 1'b1;
        2'b01:   outstanding <= outstanding - 1'b1;
        default: outstanding <= outstanding;
      endcase
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (opcode_t'(s_tuser) == OP_LOAD) begin
              if (32'(s_tdata[3:0]) < BANK_SIZE) begin
                state <= ST_LOAD;
              end
            end else if (tick_count != '0) begin
              state <= ST_TICK;
            end
          end
        end
        ST_LOAD: begin
          state <= ST_IDLE;
        end
        ST_TICK: begin
          if (issue && (osc_cnt == last_cnt)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture load fields and walk the oscillator counter
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ld_idx   <= s_tdata[3:0];
      ld_inc   <= s_tdata[35:4];
      ld_wcos  <= s_tdata[51:36];
      ld_wsin  <= s_tdata[67:52];
      ld_off   <= s_tdata[99:68];
      osc_cnt  <= '0;
      last_cnt <= INDEX_W'(tick_count - 1'b1);
    end else if (issue) begin
      osc_cnt <= osc_cnt + 1'b1;
    end
  end

  // Pass tags and weights down the pipeline
  always_ff @(posedge clk) begin
    s1_tag.last  <= (osc_cnt == last_cnt);
    s1_tag.index <= osc_cnt;
    s2_tag       <= s1_tag;
    s2_wcos      <= s1_entry.wcos;
    s2_wsin      <= s1_entry.wsin;
  end

  // Start phase, modulo a full turn
  assign ld_phase = ld_inc * ld_off;

  // Write either a fresh load or the advanced phase
  assign wr_en   = (state == ST_LOAD) || s1_valid;
  assign wr_load = (state == ST_LOAD);
  assign wr_addr = wr_load ? BANK_IDX_W'(ld_idx) : BANK_IDX_W'(s1_tag.index);

  always_comb begin
    if (wr_load) begin
      wr_entry.phase = ld_phase;
      wr_entry.incr  = ld_inc;
      wr_entry.wcos  = ld_wcos;
      wr_entry.wsin  = ld_wsin;
    end else begin
      wr_entry       = s1_entry;
      wr_entry.phase = s1_entry.phase + s1_entry.incr;
    end
  end

  // Table addresses from the top phase bits
  assign cos_addr = s1_entry.phase[PHASE_W-1 -: TABLE_BITS];
  assign sin_addr = cos_addr - TABLE_BITS'(TABLE_LEN / 4);

  sob_osc_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (issue),
    .rd_addr  (BANK_IDX_W'(osc_cnt)),
    .rd_entry (s1_entry),
    .wr_en    (wr_en),
    .wr_load  (wr_load),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  sob_cos_rom u_rom (
    .clk      (clk),
    .cos_addr (cos_addr),
    .sin_addr (sin_addr),
    .cos_val  (cos_val),
    .sin_val  (sin_val)
  );

  sob_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s2_valid),
    .in_tag     (s2_tag),
    .wcos       (s2_wcos),
    .wsin       (s2_wsin),
    .cos_val    (cos_val),
    .sin_val    (sin_val),
    .out_valid  (res_valid),
    .out_result (res)
  );

  sob_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  // Pack the output stream
  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_res.value, out_res.index};
  assign m_tlast = out_res.last;

endmodule

/* hdl/sob_osc_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sob_osc_store
// Oscillator state memory: one entry per oscillator, one write and one
// registered read per cycle. Valid bits make unloaded entries read as zero.
// ----------------------------------------------------------------------------
module sob_osc_store (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [sob_pkg::BANK_IDX_W-1:0]  rd_addr,
  output sob_pkg::osc_entry_t             rd_entry,
  input  logic                            wr_en,
  input  logic                            wr_load,
  input  logic [sob_pkg::BANK_IDX_W-1:0]  wr_addr,
  input  sob_pkg::osc_entry_t             wr_entry
);
  import sob_pkg::*;

  osc_entry_t             mem [BANK_SIZE];
  logic [BANK_SIZE-1:0]   loaded;
  osc_entry_t             rd_raw;
  logic                   rd_loaded;

  // Write and read the entry array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // Track which entries hold a load since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded    <= '0;
      rd_loaded <= 1'b0;
    end else begin
      if (wr_en && wr_load) begin
        loaded[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_loaded <= loaded[rd_addr];
      end
    end
  end

  // Mask entries never loaded to their reset value
  assign rd_entry = rd_loaded ? rd_raw : '0;

endmodule

/* hdl/sob_cos_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sob_cos_rom
// Cosine table with two registered read ports, one for cosine and one for
// sine (cosine a quarter turn back).
// ----------------------------------------------------------------------------
module sob_cos_rom (
  input  logic                               clk,
  input  logic [sob_pkg::TABLE_BITS-1:0]     cos_addr,
  input  logic [sob_pkg::TABLE_BITS-1:0]     sin_addr,
  output logic signed [sob_pkg::SAMPLE_W-1:0] cos_val,
  output logic signed [sob_pkg::SAMPLE_W-1:0] sin_val
);
  import sob_pkg::*;

  // Register both look-ups
  always_ff @(posedge clk) begin
    cos_val <= COS_ROM[cos_addr];
    sin_val <= COS_ROM[sin_addr];
  end

endmodule

/* hdl/sob_mix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sob_mix
// Weighted sum of cosine and sine: products registered, then added.
// ----------------------------------------------------------------------------
module sob_mix (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  sob_pkg::tick_tag_t                  in_tag,
  input  logic signed [sob_pkg::WEIGHT_W-1:0] wcos,
  input  logic signed [sob_pkg::WEIGHT_W-1:0] wsin,
  input  logic signed [sob_pkg::SAMPLE_W-1:0] cos_val,
  input  logic signed [sob_pkg::SAMPLE_W-1:0] sin_val,
  output logic                                out_valid,
  output sob_pkg::result_t                    out_result
);
  import sob_pkg::*;

  logic signed [VALUE_W-1:0] prod_c;
  logic signed [VALUE_W-1:0] prod_s;
  tick_tag_t                 prod_tag;
  logic                      prod_valid;

  // Hold the valid flag of the product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= in_valid;
    end
  end

  // Register both products
  always_ff @(posedge clk) begin
    prod_c   <= VALUE_W'(wcos) * VALUE_W'(cos_val);
    prod_s   <= VALUE_W'(wsin) * VALUE_W'(sin_val);
    prod_tag <= in_tag;
  end

  // Add, wrapping to 32 bits
  assign out_valid        = prod_valid;
  assign out_result.last  = prod_tag.last;
  assign out_result.index = prod_tag.index;
  assign out_result.value = prod_c + prod_s;

endmodule

/* hdl/sob_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sob_out_fifo
// Result queue between the tick pipeline and the output stream. The
// sequencer never lets more results be in flight than it can hold.
// ----------------------------------------------------------------------------
module sob_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sob_pkg::result_t push_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sob_pkg::result_t out_data
);
  import sob_pkg::*;

  result_t               slots [OUT_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W:0]   count;
  logic                  pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* tb/sv/sine_oscillator_bank_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_oscillator_bank_tb
// Self-checking bench for the sine oscillator bank.
// ----------------------------------------------------------------------------
// Load and tick commands are fed from a queue by a clocked driver, and every
// accepted command is run through a local model of the bank: its own cosine
// table, phase accumulators and weights. A clocked monitor compares each
// output sample, field by field, against the oldest predicted sample. The
// run starts with hand-picked commands covering weight and phase extremes and
// every in-use count case, then continues with random segments, each under a
// fresh in-use count, with random stalls on either side but in the last three.
// ----------------------------------------------------------------------------
module sine_oscillator_bank_tb;
  import sob_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 32;
  localparam int SEGMENTS = 9;
  localparam int SEGMENT_LEN = 49;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    opcode_t            op;
    logic [3:0]         idx;
    logic [31:0]        incr;
    logic signed [15:0] wcos;
    logic signed [15:0] wsin;
    logic [31:0]        offset;
    logic               drain;
  } bank_cmd_t;

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] value;
    logic               last;
  } osc_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  // Local copy of the bank
  logic signed [15:0] cos_lut [1024];
  logic [31:0]        osc_phase [16];
  logic [31:0]        osc_incr [16];
  logic signed [15:0] osc_wcos [16];
  logic signed [15:0] osc_wsin [16];
  logic [4:0]         in_use_m = 5'd16;

  bank_cmd_t   bank_cmds[$];
  osc_sample_t expected_samples[$];

  int items_queued = 0;
  int items_accepted = 0;
  int ticks_accepted = 0;
  int samples_checked = 0;
  int settings_written = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 9;
  int sink_idle_pct = 77;

  sine_oscillator_bank dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // (a*b) >> 62, low 64 bits kept
  function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Cosine (odd = 0) or sine (odd = 1) of x in Q62, x below a quarter turn
  function automatic logic [63:0] taylor_q62(input logic [63:0] x, input logic odd);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        div;
    logic signed [63:0] acc;
    x2   = q62_product(x, x);
    term = odd ? x : (64'd1 << 62);
    acc  = term;
    for (int n = 1; n <= 16; n++) begin
      div  = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = q62_product(term, x2) / div;
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    return acc;
  endfunction

  // Fill the cosine table, one quadrant at a time, rounded half away from zero
  task automatic build_cos_lut();
    logic [63:0] step_hi;
    logic [63:0] step_lo;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] c;
    logic [63:0] mag;
    int          quad;
    step_hi = 64'h6487_ED51_10B4_611A >> 8;
    step_lo = 64'h6487_ED51_10B4_611A & 64'hFF;
    for (int k = 0; k < 1024; k++) begin
      quad = k >> 8;
      r    = 64'(k & 255);
      x    = step_hi * r + ((step_lo * r) >> 8);
      c    = taylor_q62(x, quad[0]);
      mag  = ((c >> 30) * 64'd32767 + 64'h8000_0000) >> 32;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      cos_lut[k] = (quad == 1 || quad == 2) ? -$signed(mag[15:0]) : $signed(mag[15:0]);
    end
  endtask

  // Apply one accepted command to the local bank, queueing any samples it emits
  task automatic advance_bank(input bank_cmd_t c);
    int                 n;
    logic [9:0]         ci;
    logic [9:0]         si;
    osc_sample_t        s;
    if (c.op == OP_LOAD) begin
      osc_incr[c.idx]  = c.incr;
      osc_wcos[c.idx]  = c.wcos;
      osc_wsin[c.idx]  = c.wsin;
      osc_phase[c.idx] = c.incr * c.offset;
    end else begin
      n = (in_use_m > TICK_LIMIT) ? TICK_LIMIT : in_use_m;
      for (int k = 0; k < n; k++) begin
        ci      = osc_phase[k][31:22];
        si      = ci - 10'd256;
        s.idx   = 4'(k);
        s.value = 32'(osc_wcos[k]) * 32'(cos_lut[ci]) + 32'(osc_wsin[k]) * 32'(cos_lut[si]);
        s.last  = (k + 1 == n);
        expected_samples.push_back(s);
        osc_phase[k] = osc_phase[k] + osc_incr[k];
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED) begin
      $display("sine_oscillator_bank_tb: mismatch at %0t ns: %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic bank_cmd_t load_cmd(input logic [3:0] idx, input logic [31:0] incr,
                                         input logic [15:0] wc, input logic [15:0] ws,
                                         input logic [31:0] offset);
    bank_cmd_t c;
    c.op     = OP_LOAD;
    c.idx    = idx;
    c.incr   = incr;
    c.wcos   = wc;
    c.wsin   = ws;
    c.offset = offset;
    c.drain  = 1'b0;
    return c;
  endfunction

  // Tick; the remaining fields carry filler that the block must ignore
  function automatic bank_cmd_t tick_cmd(input logic ones);
    bank_cmd_t c;
    c.op     = OP_TICK;
    c.idx    = {4{ones}};
    c.incr   = {32{ones}};
    c.wcos   = {16{ones}};
    c.wsin   = {16{ones}};
    c.offset = {32{ones}};
    c.drain  = 1'b0;
    return c;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'(1) << $urandom_range(31);
      3: return 32'(32'($urandom_range(1023)) << 22);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bank_cmd_t random_cmd();
    bank_cmd_t c;
    if ($urandom_range(1) == 0) begin
      c = tick_cmd(1'b0);
      c.idx    = 4'($urandom);
      c.incr   = $urandom;
      c.wcos   = 16'($urandom);
      c.wsin   = 16'($urandom);
      c.offset = $urandom;
    end else begin
      c = load_cmd(4'($urandom), pick_word(), pick_weight(), pick_weight(), pick_word());
    end
    c.drain = ($urandom_range(39) == 0);
    return c;
  endfunction

  task automatic queue_cmd(input bank_cmd_t c);
    bank_cmds.push_back(c);
    items_queued++;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || expected_samples.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the in-use count once the bank has gone quiet
  task automatic set_in_use(input logic [4:0] n);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data  <= n;
    cfg_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    in_use_m = n;
    settings_written++;
  endtask

  // Driver: present queued commands, predict each one as it transfers
  always @(posedge clk) begin
    bank_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        c = bank_cmds.pop_front();
        advance_bank(c);
        items_accepted++;
        if (c.op == OP_TICK) begin
          ticks_accepted++;
        end
      end
      if (!s_tvalid || s_tready) begin
        if (bank_cmds.size() != 0
            && !(bank_cmds[0].drain && expected_samples.size() != 0)
            && $urandom_range(99) >= sender_idle_pct) begin
          c = bank_cmds[0];
          s_tvalid <= 1'b1;
          s_tuser  <= c.op;
          s_tdata  <= {4'd0, c.offset, c.wsin, c.wcos, c.incr, c.idx};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each sample transfer against the oldest prediction
  always @(posedge clk) begin
    osc_sample_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample, index %0d value %0d",
                                    m_tdata[3:0], $signed(m_tdata[35:4])));
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (m_tdata[3:0] !== want.idx) begin
            report_mismatch($sformatf("source_index %0d, expected %0d",
                                      m_tdata[3:0], want.idx));
          end
          if (m_tdata[35:4] !== want.value) begin
            report_mismatch($sformatf("osc %0d weighted_value %0d, expected %0d",
                                      want.idx, $signed(m_tdata[35:4]), want.value));
          end
          if (m_tlast !== want.last) begin
            report_mismatch($sformatf("osc %0d last_of_tick %0b, expected %0b",
                                      want.idx, m_tlast, want.last));
          end
        end
      end
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: end the run if nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("sine_oscillator_bank_tb: timeout after %0d quiet cycles", STALL_LIMIT);
      $display("sine_oscillator_bank_tb: FAIL");
      $finish;
    end
  end

  initial begin
    bank_cmd_t c;
    build_cos_lut();
    for (int k = 0; k < 16; k++) begin
      osc_phase[k] = '0;
      osc_incr[k]  = '0;
      osc_wcos[k]  = '0;
      osc_wsin[k]  = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: cleared bank, weight and phase extremes, reset in-use count
    queue_cmd(tick_cmd(1'b0));
    queue_cmd(load_cmd(4'd0, 32'h0000_0000, 16'h7FFF, 16'h0000, 32'h0000_0000));
    queue_cmd(load_cmd(4'd15, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 32'hFFFF_FFFF));
    queue_cmd(load_cmd(4'd1, 32'h4000_0000, 16'h0000, 16'h7FFF, 32'h0000_0001));
    queue_cmd(load_cmd(4'd2, 32'h8000_0000, 16'h8000, 16'h7FFF, 32'h0000_0003));
    queue_cmd(load_cmd(4'd3, 32'h0040_0000, 16'd20000, -16'sd20000, 32'h0000_00FF));
    queue_cmd(load_cmd(4'd4, 32'h003F_FFFF, 16'h0001, 16'hFFFF, 32'h8000_0000));
    c = tick_cmd(1'b1);
    c.drain = 1'b1;
    queue_cmd(c);
    queue_cmd(tick_cmd(1'b0));
    queue_cmd(tick_cmd(1'b1));
    queue_cmd(load_cmd(4'd0, 32'h1234_5678, 16'hFFFF, 16'h0001, 32'h0000_0007));
    queue_cmd(tick_cmd(1'b0));

    // Directed: in-use count at one, zero, beyond the bank and full
    set_in_use(5'd1);
    queue_cmd(tick_cmd(1'b0));
    queue_cmd(tick_cmd(1'b1));
    set_in_use(5'd0);
    queue_cmd(tick_cmd(1'b0));
    queue_cmd(load_cmd(4'd5, 32'h0100_0000, 16'h4000, 16'hC000, 32'h0000_0010));
    queue_cmd(tick_cmd(1'b1));
    set_in_use(5'd31);
    queue_cmd(tick_cmd(1'b0));
    queue_cmd(tick_cmd(1'b0));
    set_in_use(5'd17);
    queue_cmd(tick_cmd(1'b1));
    set_in_use(5'd16);
    queue_cmd(tick_cmd(1'b0));

    // Random segments: sender idles little and receiver much, swapped, then none
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if ($urandom_range(3) == 0) begin
        set_in_use(5'($urandom_range(31)));
      end else begin
        set_in_use(5'($urandom_range(1, 16)));
      end
      if (seg == 3) begin
        sender_idle_pct = 77;
        sink_idle_pct   = 9;
      end else if (seg == 6) begin
        sender_idle_pct = 0;
        sink_idle_pct   = 0;
      end
      for (int i = 0; i < SEGMENT_LEN; i++) begin
        queue_cmd(random_cmd());
      end
    end

    // Let the last samples out, then allow for any trailing output
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    error_count += expected_samples.size();

    $display("sine_oscillator_bank_tb: %0d commands (%0d ticks), %0d samples compared,",
             items_accepted, ticks_accepted, samples_checked);
    $display("sine_oscillator_bank_tb: %0d in-use counts written, %0d errors",
             settings_written, error_count);
    if (error_count == 0) begin
      $display("sine_oscillator_bank_tb: PASS");
    end else begin
      $display("sine_oscillator_bank_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sine_oscillator_bank.f */
hdl/sob_pkg.sv
hdl/sob_osc_store.sv
hdl/sob_cos_rom.sv
hdl/sob_mix.sv
hdl/sob_out_fifo.sv
hdl/sine_oscillator_bank.sv
tb/sv/sine_oscillator_bank_tb.sv
